FILE: rtl/core/bgl_pkg.sv
// ----------------------------------------------------------------------------
// Battery gauge LED controller package
// Shared item types, voltage thresholds and charger codes.
// ----------------------------------------------------------------------------
package bgl_pkg;

  // Voltage thresholds in millivolts.
  localparam logic [12:0] MvFull     = 13'd4200;
  localparam logic [12:0] MvEmpty    = 13'd3300;
  localparam logic [12:0] MvFullShow = 13'd4150;
  localparam logic [12:0] MvLed4     = 13'd4050;
  localparam logic [12:0] MvLed3     = 13'd3850;
  localparam logic [12:0] MvLed2     = 13'd3700;
  localparam logic [12:0] MvLed1     = 13'd3500;
  localparam logic [12:0] MvLow      = 13'd3500;
  localparam logic [12:0] MvCut      = 13'd3300;
  localparam logic [12:0] MvCutClear = 13'd3400;  // cutoff level plus 100 mV hysteresis

  // Reciprocal of 9 scaled by 2^13: floor(d * 911 / 8192) equals d / 9 for d below 1170.
  localparam logic [9:0]  PctRecip   = 10'd911;
  localparam int unsigned PctShift   = 13;

  localparam logic [6:0]  PctMax     = 7'd100;
  localparam logic [2:0]  LedsMax    = 3'd4;

  // Raw charger pin codes.
  localparam logic [1:0]  ChgCharging = 2'd1;
  localparam logic [1:0]  ChgFull     = 2'd2;

  // Register reset values.
  localparam logic [2:0]  RstMaxLed   = 3'd4;
  localparam logic [15:0] RstShowMs   = 16'd5000;
  localparam logic [15:0] RstUpdateMs = 16'd1000;
  localparam logic [15:0] RstAnimMs   = 16'd500;

  typedef struct packed {
    logic [12:0] sample_mv;
    logic        usb_present;
    logic [1:0]  charger_state;
    logic        switch_level;
    logic        show_request;
    logic        hide_request;
  } in_item_t;

  typedef struct packed {
    logic [3:0] led_mask;
    logic       force_pwm_zero;
    logic       cutoff_flag;
    logic [6:0] charge_percent;
    logic [2:0] lit_count;
    logic       low_flag;
    logic       visible_flag;
  } out_item_t;

  // Configuration as the tick logic sees it.
  typedef struct packed {
    logic [2:0]  eff_max;
    logic [15:0] show_duration_ms;
    logic [15:0] update_period_ms;
    logic [15:0] anim_period_ms;
  } cfg_t;

  // Values the block latches from one voltage sample.
  typedef struct packed {
    logic [12:0] mv;
    logic [6:0]  percent;
    logic [2:0]  count;
  } scale_t;

endpackage

FILE: rtl/core/bgl_volt_scale.sv
// ----------------------------------------------------------------------------
// Battery gauge voltage scaler
// Converts a millivolt sample to a clamped percent and an LED count.
// ----------------------------------------------------------------------------
module bgl_volt_scale import bgl_pkg::*; (
  input  logic [12:0] mv_i,
  input  logic [2:0]  eff_max_i,
  output scale_t      scale_o
);

  logic [12:0] delta;
  logic [19:0] product;
  logic [2:0]  raw_count;

  assign delta   = mv_i - MvEmpty;
  assign product = {10'd0, delta[9:0]} * {10'd0, PctRecip};

  always_comb begin
    scale_o.mv = mv_i;

    if (mv_i >= MvFull) begin
      scale_o.percent = PctMax;
    end else if (mv_i <= MvEmpty) begin
      scale_o.percent = 7'd0;
    end else begin
      // Span is 900 mV, so the percent is the offset divided by nine.
      scale_o.percent = product[PctShift +: 7];
    end

    priority if (mv_i >= MvLed4) begin
      raw_count = 3'd4;
    end else if (mv_i >= MvLed3) begin
      raw_count = 3'd3;
    end else if (mv_i >= MvLed2) begin
      raw_count = 3'd2;
    end else if (mv_i >= MvLed1) begin
      raw_count = 3'd1;
    end else begin
      raw_count = 3'd0;
    end

    scale_o.count = (raw_count > eff_max_i) ? eff_max_i : raw_count;
  end

endmodule

FILE: rtl/core/bgl_tick_core.sv
// ----------------------------------------------------------------------------
// Battery gauge tick core
// Holds the gauge state and works out one tick's state update and result.
// ----------------------------------------------------------------------------
module bgl_tick_core import bgl_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      step_i,
  input  in_item_t  item_i,
  input  scale_t    scale_i,
  input  cfg_t      cfg_i,
  output out_item_t result_o
);

  typedef enum logic [1:0] {
    MODE_NONE = 2'd0,
    MODE_CHG  = 2'd1,
    MODE_FULL = 2'd2
  } mode_e;

  function automatic mode_e charge_mode(logic usb, logic [1:0] cs, logic [12:0] mv);
    mode_e m;
    if (!usb) begin
      m = MODE_NONE;
    end else if (cs == ChgFull && mv >= MvFullShow) begin
      m = MODE_FULL;
    end else begin
      m = MODE_CHG;
    end
    return m;
  endfunction

  function automatic logic [3:0] count_mask(logic [2:0] c, logic [2:0] mx);
    logic [2:0] ce;
    logic [4:0] ones;
    ce   = (c > mx) ? mx : c;
    ones = (5'd1 << ce) - 5'd1;
    return ones[3:0];
  endfunction

  function automatic logic [3:0] full_mask(logic [2:0] mx);
    return (mx >= LedsMax) ? 4'hF : 4'h7;
  endfunction

  function automatic logic [3:0] redraw(mode_e mode, logic [2:0] mx, logic [2:0] cnt,
                                        logic [12:0] mv, logic cp, logic lp, logic wo);
    logic [3:0] cur;
    logic [3:0] nxt;
    logic [3:0] m;
    cur = 4'h0;
    nxt = 4'h0;
    unique case (mode)
      MODE_FULL: m = full_mask(mx);
      MODE_CHG: begin
        if (mx == 3'd0) begin
          m = 4'h0;
        end else begin
          if (cnt >= mx) begin
            cur = count_mask(mx - 3'd1, mx);
            nxt = full_mask(mx);
          end else begin
            cur = count_mask(cnt, mx);
            nxt = cur | (4'd1 << cnt[1:0]);
          end
          m = cp ? nxt : cur;
        end
      end
      default: begin
        if (mv < MvLow) begin
          m = {3'b000, lp};
        end else begin
          m = wo ? count_mask(cnt, mx) : 4'h0;
        end
      end
    endcase
    return m;
  endfunction

  // State registers.
  logic [12:0] held_mv_q, held_mv_d;
  logic [6:0]  held_pct_q, held_pct_d;
  logic [2:0]  held_cnt_q, held_cnt_d;
  logic        win_open_q, win_open_d;
  logic [15:0] win_rem_q, win_rem_d;
  logic [15:0] upd_tmr_q, upd_tmr_d;
  logic [15:0] anim_tmr_q, anim_tmr_d;
  logic        chg_phase_q, chg_phase_d;
  logic        low_phase_q, low_phase_d;
  logic [1:0]  low_steps_q, low_steps_d;
  logic        cutoff_q, cutoff_d;
  mode_e       prev_mode_q, prev_mode_d;
  logic        prev_usb_q;
  logic        prev_sw_q;
  logic [3:0]  mask_q, mask_d;
  logic        started_q;

  logic        usb, sw, usb_edge, sw_edge;
  logic        init_show, init_hide, late_show, any_show, last_show, last_hide;
  logic        any_latch, upd_fire, anim_fire, pwm_zero;
  logic [15:0] win_dec, upd_base, upd_inc, anim_base, anim_inc;
  logic        wo_a, wo_b;
  mode_e       mode_lat, mode_held, mode_pre;
  logic [3:0]  drawn;

  always_comb begin
    usb = item_i.usb_present || item_i.charger_state == ChgCharging ||
          item_i.charger_state == ChgFull;
    sw  = item_i.switch_level;

    // The first tick after reset records the pin levels, so no edge is seen then.
    usb_edge = started_q && (usb != prev_usb_q);
    sw_edge  = started_q && (sw != prev_sw_q) && !usb;

    init_show = !started_q && !usb && sw;
    init_hide = !started_q && !usb && !sw;
    late_show = item_i.show_request || (usb_edge && !usb) || sw_edge;
    any_show  = init_show || late_show;
    last_show = late_show || (init_show && !item_i.hide_request);
    last_hide = !last_show && (item_i.hide_request || init_hide);

    // Timers restart on the first tick, count up saturating and fire at the period.
    upd_base   = started_q ? upd_tmr_q : 16'd0;
    upd_inc    = (upd_base != 16'hFFFF) ? upd_base + 16'd1 : upd_base;
    upd_fire   = upd_inc >= cfg_i.update_period_ms;
    upd_tmr_d  = upd_fire ? 16'd0 : upd_inc;
    anim_base  = started_q ? anim_tmr_q : 16'd0;
    anim_inc   = (anim_base != 16'hFFFF) ? anim_base + 16'd1 : anim_base;
    anim_fire  = anim_inc >= cfg_i.anim_period_ms;
    anim_tmr_d = anim_fire ? 16'd0 : anim_inc;

    // Every latch in a tick takes the same sample.
    any_latch  = !started_q || item_i.show_request || usb_edge || sw_edge || upd_fire;
    held_mv_d  = any_latch ? scale_i.mv : held_mv_q;
    held_pct_d = any_latch ? scale_i.percent : held_pct_q;
    held_cnt_d = any_latch ? scale_i.count : held_cnt_q;

    mode_lat  = charge_mode(usb, item_i.charger_state, scale_i.mv);
    mode_held = charge_mode(usb, item_i.charger_state, held_mv_d);

    win_dec   = (win_rem_q != 16'd0) ? win_rem_q - 16'd1 : 16'd0;
    win_rem_d = any_show ? cfg_i.show_duration_ms : win_dec;

    wo_a = started_q ? win_open_q : (usb || sw);
    if (item_i.hide_request) begin
      wo_a = 1'b0;
    end
    if (item_i.show_request || usb_edge || sw_edge) begin
      wo_a = 1'b1;
    end
    wo_b = (!usb && wo_a && win_rem_d == 16'd0) ? 1'b0 : wo_a;

    mode_pre    = (!started_q || usb_edge) ? mode_lat : prev_mode_q;
    prev_mode_d = upd_fire ? mode_lat : mode_pre;
    win_open_d  = (upd_fire && usb && mode_lat != mode_pre) ? 1'b1 : wo_b;

    pwm_zero = 1'b0;
    cutoff_d = cutoff_q;
    if (upd_fire) begin
      if (!usb && scale_i.mv <= MvCut) begin
        pwm_zero = 1'b1;
        cutoff_d = 1'b1;
      end else if (scale_i.mv > MvCutClear) begin
        cutoff_d = 1'b0;
      end
    end

    chg_phase_d = chg_phase_q;
    low_phase_d = low_phase_q;
    low_steps_d = low_steps_q;
    if (anim_fire) begin
      chg_phase_d = (mode_held == MODE_CHG) ? !chg_phase_q : 1'b0;
      if (held_mv_d < MvLow) begin
        // The low blink toggles on every second animation step.
        if (low_steps_q != 2'd0) begin
          low_steps_d = 2'd0;
          low_phase_d = !low_phase_q;
        end else begin
          low_steps_d = low_steps_q + 2'd1;
        end
      end else begin
        low_steps_d = 2'd0;
        low_phase_d = 1'b0;
      end
    end

    // A show redraws with the window open; a timer redraw sees the final window.
    drawn = redraw(mode_held, cfg_i.eff_max, held_cnt_d, held_mv_d, chg_phase_d,
                   low_phase_d, (upd_fire || anim_fire) ? win_open_d : 1'b1);

    if (upd_fire || anim_fire || last_show) begin
      mask_d = drawn;
    end else if (last_hide) begin
      mask_d = 4'h0;
    end else begin
      mask_d = mask_q;
    end

    result_o.led_mask       = mask_d;
    result_o.force_pwm_zero = pwm_zero;
    result_o.cutoff_flag    = cutoff_d;
    result_o.charge_percent = held_pct_d;
    result_o.lit_count      = held_cnt_d;
    result_o.low_flag       = held_mv_d < MvLow;
    result_o.visible_flag   = usb || (held_mv_d < MvLow) || win_open_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_mv_q   <= '0;
      held_pct_q  <= '0;
      held_cnt_q  <= '0;
      win_open_q  <= 1'b0;
      win_rem_q   <= '0;
      upd_tmr_q   <= '0;
      anim_tmr_q  <= '0;
      chg_phase_q <= 1'b0;
      low_phase_q <= 1'b0;
      low_steps_q <= '0;
      cutoff_q    <= 1'b0;
      prev_mode_q <= MODE_NONE;
      prev_usb_q  <= 1'b0;
      prev_sw_q   <= 1'b0;
      mask_q      <= '0;
      started_q   <= 1'b0;
    end else if (step_i) begin
      held_mv_q   <= held_mv_d;
      held_pct_q  <= held_pct_d;
      held_cnt_q  <= held_cnt_d;
      win_open_q  <= win_open_d;
      win_rem_q   <= win_rem_d;
      upd_tmr_q   <= upd_tmr_d;
      anim_tmr_q  <= anim_tmr_d;
      chg_phase_q <= chg_phase_d;
      low_phase_q <= low_phase_d;
      low_steps_q <= low_steps_d;
      cutoff_q    <= cutoff_d;
      prev_mode_q <= prev_mode_d;
      prev_usb_q  <= usb;
      prev_sw_q   <= sw;
      mask_q      <= mask_d;
      started_q   <= 1'b1;
    end
  end

endmodule

FILE: rtl/core/battery_gauge_led_controller.sv
// ----------------------------------------------------------------------------
// Battery gauge LED controller
// Millisecond tick processor that drives the battery LEDs and the cutoff flag.
// ----------------------------------------------------------------------------
//
//   Port group   Direction  Handshake               Carries
//   in_*         sink       in_valid_i / in_stall_o    one tick (in_item_t)
//   out_*        source     out_valid_o / out_stall_i  one result (out_item_t)
//   APB          slave      psel / penable / pready    four config registers
//
// One tick is accepted every cycle while in_stall_o is low. A tick waits in
// the input register until the result register is free, then goes through
// the single state-update pass in the tick core into the result register.
// Reset clears all control state and loads the register defaults. While a
// result waits, the next tick still enters the input register; only when
// both registers are full and out_stall_i is high does in_stall_o rise.
//
// Register map (byte addresses): 0x0 max_led_count, 0x4 show_duration_ms,
// 0x8 update_period_ms, 0xC anim_period_ms.
// ----------------------------------------------------------------------------
module battery_gauge_led_controller import bgl_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_item_t    in_data_i,

  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_item_t   out_data_o,

  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  typedef enum logic [1:0] {
    REG_MAX_LED   = 2'd0,
    REG_SHOW_MS   = 2'd1,
    REG_UPDATE_MS = 2'd2,
    REG_ANIM_MS   = 2'd3
  } reg_idx_e;

  // Configuration registers.
  logic [2:0]  max_led_q;
  logic [15:0] show_ms_q;
  logic [15:0] update_ms_q;
  logic [15:0] anim_ms_q;
  logic        cfg_write;
  reg_idx_e    reg_idx;
  cfg_t        cfg;

  // Pipeline registers.
  logic        in_valid_q;
  in_item_t    in_item_q;
  logic        out_valid_q;
  out_item_t   out_item_q;
  logic        out_free;
  logic        step;
  logic        in_take;

  scale_t      scale;
  out_item_t   result;

  // The APB port never waits; a write lands in the access phase.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign reg_idx   = reg_idx_e'(paddr[3:2]);

  always_comb begin
    unique case (reg_idx)
      REG_MAX_LED:   prdata = {29'd0, max_led_q};
      REG_SHOW_MS:   prdata = {16'd0, show_ms_q};
      REG_UPDATE_MS: prdata = {16'd0, update_ms_q};
      REG_ANIM_MS:   prdata = {16'd0, anim_ms_q};
      default:       prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_led_q   <= RstMaxLed;
      show_ms_q   <= RstShowMs;
      update_ms_q <= RstUpdateMs;
      anim_ms_q   <= RstAnimMs;
    end else if (cfg_write) begin
      unique case (reg_idx)
        REG_MAX_LED:   max_led_q   <= pwdata[2:0];
        REG_SHOW_MS:   show_ms_q   <= pwdata[15:0];
        REG_UPDATE_MS: update_ms_q <= pwdata[15:0];
        REG_ANIM_MS:   anim_ms_q   <= pwdata[15:0];
        default:       max_led_q   <= max_led_q;
      endcase
    end
  end

  // Values above four fitted LEDs behave as four.
  assign cfg.eff_max          = (max_led_q > LedsMax) ? LedsMax : max_led_q;
  assign cfg.show_duration_ms = show_ms_q;
  assign cfg.update_period_ms = update_ms_q;
  assign cfg.anim_period_ms   = anim_ms_q;

  // The tick in the input register moves on whenever the result register is
  // empty or its result is taken in this cycle.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign step       = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (step) begin
        in_valid_q <= 1'b0;
      end
      if (step) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_item_q <= in_data_i;
    end
    if (step) begin
      out_item_q <= result;
    end
  end

  bgl_volt_scale u_scale (
    .mv_i      (in_item_q.sample_mv),
    .eff_max_i (cfg.eff_max),
    .scale_o   (scale)
  );

  bgl_tick_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .item_i   (in_item_q),
    .scale_i  (scale),
    .cfg_i    (cfg),
    .result_o (result)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_item_q;

endmodule

FILE: verif/tb_top.sv
// ----------------------------------------------------------------------------
// Battery gauge LED controller testbench
// Sends one-millisecond ticks through the input channel, predicts each result
// with a cycle-free model of the gauge and compares it field by field with
// what the output channel delivers. Register settings change between phases.
// ----------------------------------------------------------------------------
module tb_top;
  import bgl_pkg::*;

  // Register indexes; register i sits at byte address 4*i.
  typedef enum logic [1:0] {
    RegMaxLed,
    RegShowMs,
    RegUpdateMs,
    RegAnimMs
  } cfg_reg_e;

  // Charge state the gauge derives from the USB pin, charger pins and voltage.
  typedef enum logic [1:0] {
    ModeIdle,
    ModeCharging,
    ModeFull
  } gauge_mode_e;

  localparam logic [3:0]  FourLedPattern  = 4'hF;
  localparam logic [3:0]  ThreeLedPattern = 4'h7;
  localparam logic [1:0]  LowBlinkSteps   = 2'd2;
  localparam logic [15:0] TimerCeiling    = 16'hFFFF;
  localparam int unsigned MaxIdle         = 13;
  localparam int unsigned LongHoldCycles  = 80;
  localparam int unsigned TailCycles      = 10;

  // Clock, reset and the block's ports. Every input has a known value from
  // time zero.
  logic        clk_i    = 1'b0;
  logic        rst_n    = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_data  = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;
  logic        psel     = 1'b0;
  logic        penable  = 1'b0;
  logic        pwrite   = 1'b0;
  logic [3:0]  paddr    = '0;
  logic [31:0] pwdata   = '0;
  logic [31:0] prdata;
  logic        pready;

  battery_gauge_led_controller dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // Results the gauge owes, oldest first.
  out_item_t gauge_due[$];
  int unsigned fail_count = 0;

  // Idling controls shared between the stimulus and the receiver.
  bit tx_idle = 1'b1;
  bit rx_idle = 1'b1;
  int unsigned rx_hold_req = 0;

  // Slowly changing levels behind the random ticks, so that most sequences
  // look like a real battery: a drifting voltage and pins that rarely move.
  int cur_mv  = 3800;
  bit cur_usb = 1'b0;
  bit cur_sw  = 1'b1;
  logic [1:0] cur_chg = '0;

  // --------------------------------------------------------------------------
  // Gauge model: register copies and state.
  // --------------------------------------------------------------------------
  logic [2:0]  cfg_leds;
  logic [15:0] cfg_show, cfg_upd, cfg_anim;

  logic [12:0] held_mv;
  logic [6:0]  held_pct;
  logic [2:0]  held_cnt;
  logic        win_open;
  logic [15:0] win_left, upd_t, anim_t;
  logic        chg_phase, low_ph, cut_st, last_usb, last_sw, booted;
  logic [1:0]  low_steps;
  gauge_mode_e last_mode;
  logic [3:0]  led_pat;

  function automatic void reset_gauge_model();
    cfg_leds  = RstMaxLed;
    cfg_show  = RstShowMs;
    cfg_upd   = RstUpdateMs;
    cfg_anim  = RstAnimMs;
    held_mv   = '0;
    held_pct  = '0;
    held_cnt  = '0;
    win_open  = 1'b0;
    win_left  = '0;
    upd_t     = '0;
    anim_t    = '0;
    chg_phase = 1'b0;
    low_ph    = 1'b0;
    low_steps = '0;
    cut_st    = 1'b0;
    last_mode = ModeIdle;
    last_usb  = 1'b0;
    last_sw   = 1'b0;
    led_pat   = '0;
    booted    = 1'b0;
  endfunction

  // Register values above four fitted LEDs behave as four.
  function automatic int unsigned fitted();
    return (cfg_leds > LedsMax) ? 32'(LedsMax) : 32'(cfg_leds);
  endfunction

  function automatic bit usb_on(in_item_t t);
    return t.usb_present || t.charger_state == ChgCharging || t.charger_state == ChgFull;
  endfunction

  function automatic gauge_mode_e mode_of(in_item_t t);
    if (!usb_on(t)) return ModeIdle;
    if (t.charger_state == ChgFull && held_mv >= MvFullShow) return ModeFull;
    return ModeCharging;
  endfunction

  function automatic void take_sample(in_item_t t);
    int unsigned mv, c;
    mv = 32'(t.sample_mv);
    held_mv = t.sample_mv;
    if (mv >= MvFull) held_pct = PctMax;
    else if (mv <= MvEmpty) held_pct = '0;
    else held_pct = 7'((mv - MvEmpty) * PctMax / (MvFull - MvEmpty));
    if (mv >= MvLed4) c = 4;
    else if (mv >= MvLed3) c = 3;
    else if (mv >= MvLed2) c = 2;
    else if (mv >= MvLed1) c = 1;
    else c = 0;
    if (c > fitted()) c = fitted();
    held_cnt = 3'(c);
  endfunction

  function automatic logic [3:0] full_pat();
    return (fitted() >= LedsMax) ? FourLedPattern : ThreeLedPattern;
  endfunction

  function automatic logic [3:0] count_pat(int unsigned c);
    if (c > fitted()) c = fitted();
    return 4'((1 << c) - 1);
  endfunction

  function automatic void redraw_leds(in_item_t t);
    gauge_mode_e m;
    int unsigned mx;
    logic [3:0] cur, nxt;
    m  = mode_of(t);
    mx = fitted();
    if (m == ModeFull) begin
      led_pat = full_pat();
    end else if (m == ModeCharging) begin
      if (mx == 0) begin
        led_pat = '0;
      end else begin
        // The charge blink lights the next LED; at the top it blinks to full.
        if (held_cnt >= mx) begin
          cur = count_pat(mx - 1);
          nxt = full_pat();
        end else begin
          cur = count_pat(held_cnt);
          nxt = cur | 4'(1 << held_cnt);
        end
        led_pat = chg_phase ? nxt : cur;
      end
    end else if (held_mv < MvLow) begin
      led_pat = {3'b000, low_ph};
    end else begin
      led_pat = win_open ? count_pat(held_cnt) : 4'h0;
    end
  endfunction

  function automatic void open_window(in_item_t t);
    take_sample(t);
    win_open = 1'b1;
    win_left = cfg_show;
    redraw_leds(t);
  endfunction

  function automatic void close_window();
    win_open = 1'b0;
    led_pat  = '0;
  endfunction

  // Saturating up-count; the top bit of the result says the period was hit.
  function automatic logic [16:0] timer_next(logic [15:0] t, logic [15:0] period);
    if (t < TimerCeiling) t = t + 16'd1;
    if (t >= period) return {1'b1, 16'd0};
    return {1'b0, t};
  endfunction

  // Advances the model by one tick and returns the result it produces.
  function automatic out_item_t gauge_result(in_item_t t);
    bit usb, sw, pwm0;
    logic [16:0] tn;
    gauge_mode_e m;
    out_item_t r;
    usb  = usb_on(t);
    sw   = t.switch_level;
    pwm0 = 1'b0;
    if (win_left != 0) win_left = win_left - 16'd1;

    if (!booted) begin
      booted    = 1'b1;
      upd_t     = '0;
      anim_t    = '0;
      take_sample(t);
      last_mode = mode_of(t);
      last_usb  = usb;
      last_sw   = sw;
      if (usb) win_open = 1'b1;
      else if (sw) open_window(t);
      else close_window();
    end

    // Hide first so that a show in the same tick wins.
    if (t.hide_request) close_window();
    if (t.show_request) open_window(t);

    if (usb != last_usb) begin
      last_usb = usb;
      if (usb) begin
        win_open  = 1'b1;
        take_sample(t);
        last_mode = mode_of(t);
      end else begin
        open_window(t);
        last_mode = ModeIdle;
      end
    end

    if (sw != last_sw && !usb) open_window(t);
    last_sw = sw;

    if (!usb && win_open && win_left == 0) win_open = 1'b0;

    tn = timer_next(upd_t, cfg_upd);
    upd_t = tn[15:0];
    if (tn[16]) begin
      take_sample(t);
      m = mode_of(t);
      if (m != last_mode) begin
        last_mode = m;
        if (usb) win_open = 1'b1;
      end
      if (!usb && held_mv <= MvCut) begin
        pwm0   = 1'b1;
        cut_st = 1'b1;
      end else if (held_mv > MvCutClear) begin
        cut_st = 1'b0;
      end
      redraw_leds(t);
    end

    tn = timer_next(anim_t, cfg_anim);
    anim_t = tn[15:0];
    if (tn[16]) begin
      if (mode_of(t) == ModeCharging) chg_phase = ~chg_phase;
      else chg_phase = 1'b0;
      // The low blink toggles on every second animation step.
      if (held_mv < MvLow) begin
        low_steps = low_steps + 2'd1;
        if (low_steps >= LowBlinkSteps) begin
          low_steps = '0;
          low_ph    = ~low_ph;
        end
      end else begin
        low_steps = '0;
        low_ph    = 1'b0;
      end
      redraw_leds(t);
    end

    r.led_mask       = led_pat;
    r.force_pwm_zero = pwm0;
    r.cutoff_flag    = cut_st;
    r.charge_percent = held_pct;
    r.lit_count      = held_cnt;
    r.low_flag       = held_mv < MvLow;
    r.visible_flag   = usb || held_mv < MvLow || win_open;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Clock and the one reset at the start of the run.
  // --------------------------------------------------------------------------
  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin
    #4000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Receiver: it takes each result transfer, checks it against the oldest
  // prediction, then stalls for a freshly drawn number of cycles. A long
  // hold-off requested by a test is counted here as well.
  // --------------------------------------------------------------------------
  task automatic check_result(out_item_t got);
    out_item_t want;
    if (gauge_due.size() == 0) begin
      $error("result transfer with no prediction waiting: %h", got);
      fail_count++;
      return;
    end
    want = gauge_due.pop_front();
    if (got.led_mask != want.led_mask) begin
      $error("led_mask expected %0h actual %0h", want.led_mask, got.led_mask);
      fail_count++;
    end
    if (got.force_pwm_zero != want.force_pwm_zero) begin
      $error("force_pwm_zero expected %0d actual %0d", want.force_pwm_zero,
             got.force_pwm_zero);
      fail_count++;
    end
    if (got.cutoff_flag != want.cutoff_flag) begin
      $error("cutoff_flag expected %0d actual %0d", want.cutoff_flag, got.cutoff_flag);
      fail_count++;
    end
    if (got.charge_percent != want.charge_percent) begin
      $error("charge_percent expected %0d actual %0d", want.charge_percent,
             got.charge_percent);
      fail_count++;
    end
    if (got.lit_count != want.lit_count) begin
      $error("lit_count expected %0d actual %0d", want.lit_count, got.lit_count);
      fail_count++;
    end
    if (got.low_flag != want.low_flag) begin
      $error("low_flag expected %0d actual %0d", want.low_flag, got.low_flag);
      fail_count++;
    end
    if (got.visible_flag != want.visible_flag) begin
      $error("visible_flag expected %0d actual %0d", want.visible_flag, got.visible_flag);
      fail_count++;
    end
  endtask

  initial begin : rx_proc
    int unsigned wait_left;
    int unsigned hold_left;
    wait_left = 0;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      // Signals read here hold their values from before this edge.
      if (rst_n && out_valid && !out_stall) begin
        check_result(out_data);
        wait_left = rx_idle ? $urandom_range(0, MaxIdle) : 0;
      end
      if (rx_hold_req != 0) begin
        hold_left   = rx_hold_req;
        rx_hold_req = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (wait_left != 0) begin
        wait_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender and register access. All of these are entered at a rising edge.
  // --------------------------------------------------------------------------

  // Offers one tick after a drawn gap and returns at the edge that takes it.
  // Valid stays high afterwards so that back-to-back ticks need no dip.
  task automatic send_tick(in_item_t t);
    int unsigned gap;
    gap = tx_idle ? $urandom_range(0, MaxIdle) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= t;
    do @(posedge clk_i); while (in_stall);
    gauge_due.push_back(gauge_result(t));
  endtask

  task automatic end_burst();
    in_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_results_drained();
    while (gauge_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic apb_write(cfg_reg_e idx, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    case (idx)
      RegMaxLed:   cfg_leds = value[2:0];
      RegShowMs:   cfg_show = value[15:0];
      RegUpdateMs: cfg_upd  = value[15:0];
      RegAnimMs:   cfg_anim = value[15:0];
      default: ;
    endcase
  endtask

  // Registers change only once the block holds no tick and owes no result.
  task automatic set_gauge_config(int unsigned leds, int unsigned show_ms,
                                  int unsigned upd_ms, int unsigned anim_ms);
    end_burst();
    wait_results_drained();
    apb_write(RegMaxLed, leds);
    apb_write(RegShowMs, show_ms);
    apb_write(RegUpdateMs, upd_ms);
    apb_write(RegAnimMs, anim_ms);
  endtask

  function automatic in_item_t tick_of(int unsigned mv, bit usb, logic [1:0] chg,
                                       bit sw, bit show_rq, bit hide_rq);
    in_item_t t;
    t.sample_mv     = 13'(mv);
    t.usb_present   = usb;
    t.charger_state = chg;
    t.switch_level  = sw;
    t.show_request  = show_rq;
    t.hide_request  = hide_rq;
    return t;
  endfunction

  function automatic int unsigned voltage_mark();
    case ($urandom_range(0, 8))
      0: return 32'(MvFull);
      1: return 32'(MvEmpty);
      2: return 32'(MvFullShow);
      3: return 32'(MvLed4);
      4: return 32'(MvLed3);
      5: return 32'(MvLed2);
      6: return 32'(MvLow);
      7: return 32'(MvCutClear);
      default: return 32'(MvCut);
    endcase
  endfunction

  // Mostly well-formed ticks with rare pin changes; one in ten is pure noise.
  function automatic in_item_t random_tick();
    int unsigned pick;
    in_item_t t;
    if ($urandom_range(0, 9) == 0) return in_item_t'($urandom());
    pick = $urandom_range(0, 99);
    if (pick < 60) cur_mv = cur_mv + int'($urandom_range(0, 80)) - 40;
    else if (pick < 75) cur_mv = $urandom_range(3200, 4300);
    else if (pick < 85) cur_mv = $urandom_range(0, 8191);
    else cur_mv = int'(voltage_mark()) + int'($urandom_range(0, 2)) - 1;
    if (cur_mv < 0) cur_mv = 0;
    if (cur_mv > 8191) cur_mv = 8191;
    if ($urandom_range(0, 99) < 3) cur_usb = ~cur_usb;
    if ($urandom_range(0, 99) < 4) cur_sw = ~cur_sw;
    if ($urandom_range(0, 99) < 5) cur_chg = 2'($urandom_range(0, 3));
    t = tick_of(cur_mv, cur_usb, cur_chg, cur_sw,
                $urandom_range(0, 99) < 8, $urandom_range(0, 99) < 6);
    return t;
  endfunction

  // --------------------------------------------------------------------------
  // Tests.
  // --------------------------------------------------------------------------

  // The first tick after reset initialises the gauge under the reset
  // register values; the switch is on, so it opens the show window.
  task automatic test_power_on();
    send_tick(tick_of(3600, 1'b0, 2'd0, 1'b1, 1'b0, 1'b0));
    send_tick(tick_of(3610, 1'b0, 2'd0, 1'b1, 1'b0, 1'b0));
    send_tick(tick_of(4300, 1'b1, 2'd1, 1'b1, 1'b0, 1'b0));
    send_tick(tick_of(3300, 1'b0, 2'd0, 1'b0, 1'b0, 1'b1));
  endtask

  // Field extremes, thresholds, every charger code and each special case.
  task automatic test_directed_cases();
    // Latch and animate every tick with a short window.
    set_gauge_config(4, 3, 1, 1);
    send_tick(tick_of(0,    1'b0, 2'd0, 1'b1, 1'b0, 1'b0));  // cutoff with PWM pulse
    send_tick(tick_of(3350, 1'b0, 2'd0, 1'b1, 1'b0, 1'b0));  // inside the hysteresis
    send_tick(tick_of(3401, 1'b0, 2'd0, 1'b1, 1'b0, 1'b0));  // cutoff clears
    send_tick(tick_of(8191, 1'b0, 2'd0, 1'b1, 1'b1, 1'b0));  // show at top voltage
    send_tick(tick_of(3499, 1'b0, 2'd0, 1'b1, 1'b0, 1'b1));  // hide while low
    send_tick(tick_of(3500, 1'b0, 2'd0, 1'b1, 1'b1, 1'b1));  // both requests, show wins
    send_tick(tick_of(3700, 1'b0, 2'd0, 1'b0, 1'b0, 1'b0));  // switch falls
    send_tick(tick_of(3850, 1'b0, 2'd0, 1'b1, 1'b0, 1'b0));  // switch rises
    send_tick(tick_of(4050, 1'b1, 2'd0, 1'b1, 1'b0, 1'b0));  // USB pin arrives
    send_tick(tick_of(4100, 1'b0, 2'd1, 1'b1, 1'b0, 1'b0));  // charging by pins alone
    send_tick(tick_of(4150, 1'b0, 2'd2, 1'b1, 1'b0, 1'b0));  // really full
    send_tick(tick_of(4200, 1'b0, 2'd2, 1'b1, 1'b0, 1'b0));
    send_tick(tick_of(4000, 1'b0, 2'd2, 1'b1, 1'b0, 1'b0));  // full pins, voltage short
    send_tick(tick_of(4200, 1'b0, 2'd3, 1'b1, 1'b0, 1'b0));  // code three is idle
    send_tick(tick_of(3200, 1'b0, 2'd0, 1'b1, 1'b0, 1'b0));  // low blink steps
    send_tick(tick_of(3200, 1'b0, 2'd0, 1'b1, 1'b0, 1'b0));
    send_tick(tick_of(3200, 1'b0, 2'd0, 1'b1, 1'b0, 1'b0));
    // Three LEDs fitted: the full pattern shrinks and the top charge blink
    // reaches it.
    set_gauge_config(3, 3, 1, 1);
    send_tick(tick_of(4200, 1'b1, 2'd2, 1'b1, 1'b0, 1'b0));
    send_tick(tick_of(4100, 1'b1, 2'd1, 1'b1, 1'b0, 1'b0));
    send_tick(tick_of(4100, 1'b1, 2'd1, 1'b1, 1'b0, 1'b0));
    // No LEDs fitted while charging, then a window of zero length.
    set_gauge_config(0, 0, 1, 1);
    send_tick(tick_of(3900, 1'b1, 2'd1, 1'b1, 1'b0, 1'b0));
    send_tick(tick_of(3900, 1'b0, 2'd0, 1'b1, 1'b1, 1'b0));
  endtask

  // Random traffic under one register setting, with idling switched on and
  // off in stretches on both sides.
  task automatic random_phase(int unsigned leds, int unsigned show_ms,
                              int unsigned upd_ms, int unsigned anim_ms, int unsigned count);
    set_gauge_config(leds, show_ms, upd_ms, anim_ms);
    for (int unsigned i = 0; i < count; i++) begin
      if (i % 40 == 0) begin
        tx_idle = $urandom_range(0, 3) != 0;
        rx_idle = $urandom_range(0, 3) != 0;
      end
      send_tick(random_tick());
    end
  endtask

  task automatic test_random_traffic();
    random_phase(4, 30, 3, 2, 110);
    random_phase(3, 0, 1, 1, 90);
    random_phase(0, 65535, 0, 0, 80);
    random_phase(7, 10, 65535, 65535, 60);
    random_phase(1, 5, 2, 5, 90);
    random_phase(2, 1000, 7, 3, 80);
  endtask

  // The receiver holds off for a long stretch while ticks keep coming with
  // no gaps, so both internal registers fill and the input stalls. Then the
  // sender pauses until every owed result is in before it resumes.
  task automatic test_backpressure();
    set_gauge_config(4, 20, 2, 1);
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    rx_hold_req = LongHoldCycles;
    for (int unsigned i = 0; i < 30; i++) send_tick(random_tick());
    end_burst();
    wait_results_drained();
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    for (int unsigned i = 0; i < 30; i++) send_tick(random_tick());
  endtask

  initial begin
    reset_gauge_model();
    repeat (11) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    test_power_on();
    test_directed_cases();
    test_random_traffic();
    test_backpressure();

    end_burst();
    wait_results_drained();
    // The tail wait catches any stray result after the last one owed.
    repeat (TailCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/bgl_pkg.sv
rtl/core/bgl_volt_scale.sv
rtl/core/bgl_tick_core.sv
rtl/core/battery_gauge_led_controller.sv
verif/tb_top.sv
